[rtl/core/iol_pkg.sv]
// Shared constants, operation codes and cell control type for the indexed ordered list.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package iol_pkg;

	localparam int DEPTH     = 64;
	localparam int ITEM_BITS = 32;
	localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	// port widths fixed by the interface
	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	// read tree: cells per first-level group
	localparam int GRP_SIZE = 8;
	localparam int NGRP     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_GET    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] MODE_HOLD   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_INSERT = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	typedef struct packed {
		logic [1:0]          mode;
		logic [IDX_BITS-1:0] pos;
		logic                rd_en;
	} ctl_t;

endpackage

[rtl/core/iol_cell.sv]
// One storage cell of the list chain: holds a single entry and trades it with its neighbors.
// Depends on iol_pkg for the control struct and mode codes.
`timescale 1ns / 1ps

module iol_cell (
	input  logic                         clk,
	input  logic [iol_pkg::IDX_BITS-1:0] idx,
	input  iol_pkg::ctl_t                ctl,
	input  logic [iol_pkg::ITEM_BITS-1:0] item,
	input  logic [iol_pkg::ITEM_BITS-1:0] left_data,
	input  logic [iol_pkg::ITEM_BITS-1:0] right_data,
	output logic [iol_pkg::ITEM_BITS-1:0] data,
	output logic [iol_pkg::ITEM_BITS-1:0] rd_word
);

	logic [iol_pkg::ITEM_BITS-1:0] data_q;
	logic [iol_pkg::ITEM_BITS-1:0] data_d;
	logic                          at_pos;
	logic                          above_pos;

	assign at_pos    = (idx == ctl.pos);
	assign above_pos = (idx > ctl.pos);

	always_comb begin
		data_d = data_q;
		case (ctl.mode)
			iol_pkg::MODE_WRITE: begin
				if (at_pos) data_d = item;
			end
			iol_pkg::MODE_INSERT: begin
				// open a gap at pos, later entries move up
				if (at_pos) data_d = item;
				else if (above_pos) data_d = left_data;
			end
			iol_pkg::MODE_REMOVE: begin
				// close the gap, later entries move down
				if (at_pos || above_pos) data_d = right_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	assign rd_word = (ctl.rd_en && at_pos) ? data_q : '0;

endmodule

[rtl/core/iol_chain.sv]
// Row of list cells with neighbor links and a registered OR tree for reads.
// Depends on iol_pkg and iol_cell.
`timescale 1ns / 1ps

module iol_chain (
	input  logic                          clk,
	input  iol_pkg::ctl_t                 ctl,
	input  logic [iol_pkg::ITEM_BITS-1:0] item,
	input  logic                          cap,
	output logic [iol_pkg::ITEM_BITS-1:0] rd_word
);

	logic [iol_pkg::ITEM_BITS-1:0] cell_data [iol_pkg::DEPTH];
	logic [iol_pkg::ITEM_BITS-1:0] cell_rd   [iol_pkg::DEPTH];
	logic [iol_pkg::ITEM_BITS-1:0] grp_d     [iol_pkg::NGRP];
	logic [iol_pkg::ITEM_BITS-1:0] grp_s1    [iol_pkg::NGRP];

	for (genvar i = 0; i < iol_pkg::DEPTH; i++) begin : g_cell
		logic [iol_pkg::ITEM_BITS-1:0] left_w;
		logic [iol_pkg::ITEM_BITS-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == iol_pkg::DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		iol_cell u_cell (
			.clk        (clk),
			.idx        (iol_pkg::IDX_BITS'(i)),
			.ctl        (ctl),
			.item       (item),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.rd_word    (cell_rd[i])
		);
	end

	// at most one cell drives a nonzero read word, so OR merges them
	always_comb begin
		for (int g = 0; g < iol_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < iol_pkg::GRP_SIZE; k++) begin
				if (g * iol_pkg::GRP_SIZE + k < iol_pkg::DEPTH)
					grp_d[g] = grp_d[g] | cell_rd[g * iol_pkg::GRP_SIZE + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			for (int g = 0; g < iol_pkg::NGRP; g++) grp_s1[g] <= grp_d[g];
		end
	end

	always_comb begin
		rd_word = '0;
		for (int g = 0; g < iol_pkg::NGRP; g++) rd_word = rd_word | grp_s1[g];
	end

endmodule

[rtl/core/indexed_ordered_list.sv]
// Top level of the indexed ordered list: decode, count tracking and result staging.
// Depends on iol_pkg and iol_chain.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | opcode, position, item_value
//   out     | output    | out_valid/out_stall| read_value, item_count, status
//
// Sustains one transaction per cycle unless out_stall backs up; an accepted
// transaction's result passes the registered read OR tree, then the output register.
// Reset clears the count and the pipeline valids; entries carry no reset and
// need no clearing pass, since only written positions are ever read.
// An out stall holds the output register; input stalls only once the first
// stage also holds a result.
`timescale 1ns / 1ps

module indexed_ordered_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [iol_pkg::OP_W-1:0]    opcode,
	input  logic [iol_pkg::POS_W-1:0]   position,
	input  logic [iol_pkg::VAL_W-1:0]   item_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [iol_pkg::VAL_W-1:0]   read_value,
	output logic [iol_pkg::COUNT_W-1:0] item_count,
	output logic [iol_pkg::STAT_W-1:0]  status
);

	logic                          accept;
	logic                          out_free;
	logic                          in_range;
	logic                          full;
	logic [iol_pkg::CNT_BITS-1:0]  count_q;
	logic [iol_pkg::CNT_BITS-1:0]  count_d;
	logic [iol_pkg::STAT_W-1:0]    st_d;
	iol_pkg::ctl_t                 ctl_d;
	iol_pkg::ctl_t                 ctl;
	logic [iol_pkg::ITEM_BITS-1:0] item;
	logic [iol_pkg::ITEM_BITS-1:0] rd_word;

	logic                          ph1_q;
	logic [iol_pkg::CNT_BITS-1:0]  cnt_s1;
	logic [iol_pkg::STAT_W-1:0]    st_s1;
	logic                          out_valid_q;
	logic [iol_pkg::VAL_W-1:0]     read_value_q;
	logic [iol_pkg::COUNT_W-1:0]   item_count_q;
	logic [iol_pkg::STAT_W-1:0]    status_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = ph1_q && !out_free;
	assign accept   = in_valid && !in_stall;

	assign item     = iol_pkg::ITEM_BITS'(item_value);
	assign in_range = iol_pkg::CNT_BITS'(position) < count_q;
	assign full     = count_q == iol_pkg::CNT_BITS'(iol_pkg::DEPTH);

	always_comb begin
		ctl_d.mode  = iol_pkg::MODE_HOLD;
		ctl_d.pos   = iol_pkg::IDX_BITS'(position);
		ctl_d.rd_en = 1'b0;
		count_d     = count_q;
		st_d        = iol_pkg::ST_OK;
		case (opcode)
			iol_pkg::OP_APPEND: begin
				if (full) begin
					st_d = iol_pkg::ST_FULL;
				end else begin
					ctl_d.mode = iol_pkg::MODE_WRITE;
					ctl_d.pos  = iol_pkg::IDX_BITS'(count_q);
					count_d    = count_q + 1'b1;
				end
			end
			iol_pkg::OP_INSERT: begin
				if (!in_range) begin
					st_d = iol_pkg::ST_RANGE;
				end else if (full) begin
					st_d = iol_pkg::ST_FULL;
				end else begin
					ctl_d.mode = iol_pkg::MODE_INSERT;
					count_d    = count_q + 1'b1;
				end
			end
			iol_pkg::OP_UPDATE: begin
				if (!in_range) st_d = iol_pkg::ST_RANGE;
				else ctl_d.mode = iol_pkg::MODE_WRITE;
			end
			iol_pkg::OP_REMOVE: begin
				if (!in_range) begin
					st_d = iol_pkg::ST_RANGE;
				end else begin
					ctl_d.mode = iol_pkg::MODE_REMOVE;
					count_d    = count_q - 1'b1;
				end
			end
			iol_pkg::OP_GET: begin
				if (!in_range) st_d = iol_pkg::ST_RANGE;
				else ctl_d.rd_en = 1'b1;
			end
			default: st_d = iol_pkg::ST_OK;
		endcase
	end

	// drop all cell activity unless a transaction is taken
	always_comb begin
		ctl = ctl_d;
		if (!accept) begin
			ctl.mode  = iol_pkg::MODE_HOLD;
			ctl.rd_en = 1'b0;
		end
	end

	iol_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.item    (item),
		.cap     (accept),
		.rd_word (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ph1_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) count_q <= count_d;
			if (accept) ph1_q <= 1'b1;
			else if (out_free) ph1_q <= 1'b0;
			if (out_free) out_valid_q <= ph1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1 <= count_d;
			st_s1  <= st_d;
		end
		if (out_free && ph1_q) begin
			read_value_q <= iol_pkg::VAL_W'(rd_word);
			item_count_q <= iol_pkg::COUNT_W'(cnt_s1);
			status_q     <= st_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign item_count = item_count_q;
	assign status     = status_q;

endmodule

[rtl/core/iol_checker.sv]
// Port-level assertions for the indexed ordered list, bound to the top level.
// Depends on iol_pkg and indexed_ordered_list.
`timescale 1ns / 1ps

module iol_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [iol_pkg::OP_W-1:0]    opcode,
	input logic [iol_pkg::POS_W-1:0]   position,
	input logic [iol_pkg::VAL_W-1:0]   item_value,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [iol_pkg::VAL_W-1:0]   read_value,
	input logic [iol_pkg::COUNT_W-1:0] item_count,
	input logic [iol_pkg::STAT_W-1:0]  status
);

	// hold a stalled transaction on the input side
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(opcode)
			&& $stable(position) && $stable(item_value))
		else $error("stalled transaction changed");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value)
			&& $stable(item_count) && $stable(status))
		else $error("stalled result changed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_count <= iol_pkg::COUNT_W'(iol_pkg::DEPTH)
			&& (status == iol_pkg::ST_OK || status == iol_pkg::ST_RANGE
				|| status == iol_pkg::ST_FULL))
		else $error("result count or status out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != iol_pkg::ST_OK |-> read_value == '0)
		else $error("failed transaction returned data");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == iol_pkg::ST_FULL
			|-> item_count == iol_pkg::COUNT_W'(iol_pkg::DEPTH))
		else $error("full status without a full list");

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (.*);
